// ----- src/ucd_pkg.sv -----
// Shared types and codes for the undirected cycle detector.
package ucd_pkg;

    // Input word: one undirected edge.
    typedef struct packed {
        logic [7:0] edge_from;
        logic [7:0] edge_to;
        logic       last_edge;
    } edge_word_t;

    // Result word.
    typedef struct packed {
        logic       cycle_found;
        logic [1:0] status;
    } result_word_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_RANGE    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [8:0] VCOUNT_RESET = 9'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_edge;
        logic root_init;
        logic root_rd;
        logic root_next;
        logic root_start;
        logic edge_rd;
        logic edge_skip;
        logic edge_hit;
        logic push;
        logic pop_rd;
        logic pop_load;
        logic out_load;
        logic out_cycle;
        logic clr_step;
    } ucd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic root_done;
        logic root_visited;
        logic scan_end;
        logic edge_match;
        logic other_visited;
        logic sp_one;
        logic clr_last;
        logic out_free;
    } ucd_stat_t;

endpackage

// ----- src/ucd_dp.sv -----
// Datapath: edge store, visited marks, search stack, counters and output register.
module ucd_dp import ucd_pkg::*; #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  ucd_cmd_t     cmd,
    output ucd_stat_t    stat,
    input  edge_word_t   in_word,
    input  logic         cfg_we,
    input  logic [8:0]   cfg_data,
    output logic         m_valid,
    input  logic         m_ready,
    output result_word_t m_data
);
    localparam int VW      = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW      = (MAX_EDGES > 2) ? $clog2(MAX_EDGES) : 1;
    localparam int LW      = $clog2(MAX_EDGES + 1);
    localparam int CNT_CAP = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
    localparam int FW      = 8 + LW + 1 + LW;

    logic [8:0]    vcount_reg;
    logic [LW-1:0] loaded_reg;
    logic          flag_range_reg;
    logic          flag_ovf_reg;
    logic [8:0]    root_reg;
    logic [7:0]    u_reg;
    logic [LW-1:0] via_reg;
    logic          via_valid_reg;
    logic [LW-1:0] e_reg;
    logic [LW-1:0] hit_reg;
    logic [7:0]    other_reg;
    logic [VW:0]   sp_reg;
    logic [VW-1:0] clr_reg;
    logic          m_valid_reg;
    result_word_t  m_data_reg;

    logic [15:0]   edge_mem [MAX_EDGES];
    logic [15:0]   edge_rd_reg;
    logic          vis_mem [MAX_VERTICES];
    logic          vis_rd_reg;
    logic [FW-1:0] stk_mem [MAX_VERTICES];
    logic [FW-1:0] stk_rd_reg;

    logic [8:0]    cnt_eff;
    logic          in_range;
    logic [7:0]    ea;
    logic [7:0]    eb;
    logic [7:0]    other;
    logic [VW-1:0] vis_raddr;
    logic [VW-1:0] vis_waddr;
    logic          vis_we;
    logic          vis_wd;
    logic [VW:0]   sp_m1;
    logic [VW:0]   sp_m2;

    // Effective vertex count and range check of the incoming edge.
    assign cnt_eff  = (vcount_reg > 9'(CNT_CAP)) ? 9'(CNT_CAP) : vcount_reg;
    assign in_range = ({1'b0, in_word.edge_from} < cnt_eff) &&
                      ({1'b0, in_word.edge_to} < cnt_eff);

    // Edge under test against the current vertex.
    assign ea    = edge_rd_reg[7:0];
    assign eb    = edge_rd_reg[15:8];
    assign other = (ea == u_reg) ? eb : ea;
    assign sp_m1 = sp_reg - 1'b1;
    assign sp_m2 = sp_reg - 2'd2;

    // Status to the controller.
    assign stat.root_done     = (root_reg >= cnt_eff);
    assign stat.root_visited  = vis_rd_reg;
    assign stat.scan_end      = (e_reg >= loaded_reg);
    assign stat.edge_match    = (!via_valid_reg || (e_reg != via_reg)) &&
                                ((ea == u_reg) || (eb == u_reg));
    assign stat.other_visited = vis_rd_reg;
    assign stat.sp_one        = (sp_reg == (VW+1)'(1));
    assign stat.clr_last      = (clr_reg == VW'(MAX_VERTICES - 1));
    assign stat.out_free      = !m_valid_reg || m_ready;

    // Visited mark port selection.
    always_comb begin
        vis_raddr = cmd.edge_hit ? VW'(other) : VW'(root_reg);
        vis_we    = cmd.root_start || cmd.push || cmd.clr_step;
        vis_wd    = !cmd.clr_step;
        if (cmd.clr_step) begin
            vis_waddr = clr_reg;
        end else if (cmd.push) begin
            vis_waddr = VW'(other_reg);
        end else begin
            vis_waddr = VW'(root_reg);
        end
    end

    // Edge store memory.
    always_ff @(posedge aclk) begin
        if (cmd.load_edge && in_range && (loaded_reg != LW'(MAX_EDGES))) begin
            edge_mem[loaded_reg[EW-1:0]] <= {in_word.edge_to, in_word.edge_from};
        end
        if (cmd.edge_rd) begin
            edge_rd_reg <= edge_mem[e_reg[EW-1:0]];
        end
    end

    // Visited mark memory.
    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wd;
        end
        if (cmd.root_rd || cmd.edge_hit) begin
            vis_rd_reg <= vis_mem[vis_raddr];
        end
    end

    // Search stack memory; the top frame lives in registers.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stk_mem[sp_m1[VW-1:0]] <= {u_reg, via_reg, via_valid_reg, e_reg};
        end
        if (cmd.pop_rd) begin
            stk_rd_reg <= stk_mem[sp_m2[VW-1:0]];
        end
    end

    // Search registers, payload only.
    always_ff @(posedge aclk) begin
        if (cmd.root_start) begin
            u_reg         <= root_reg[7:0];
            via_valid_reg <= 1'b0;
            via_reg       <= '0;
            e_reg         <= '0;
        end else if (cmd.edge_skip) begin
            e_reg <= e_reg + 1'b1;
        end else if (cmd.edge_hit) begin
            other_reg <= other;
            hit_reg   <= e_reg;
            e_reg     <= e_reg + 1'b1;
        end else if (cmd.push) begin
            u_reg         <= other_reg;
            via_reg       <= hit_reg;
            via_valid_reg <= 1'b1;
            e_reg         <= '0;
        end else if (cmd.pop_load) begin
            {u_reg, via_reg, via_valid_reg, e_reg} <= stk_rd_reg;
        end
    end

    // Control counters, flags, configuration and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg     <= VCOUNT_RESET;
            loaded_reg     <= '0;
            flag_range_reg <= 1'b0;
            flag_ovf_reg   <= 1'b0;
            root_reg       <= '0;
            sp_reg         <= '0;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                vcount_reg <= cfg_data;
            end
            if (cmd.load_edge) begin
                if (!in_range) begin
                    flag_range_reg <= 1'b1;
                end else if (loaded_reg == LW'(MAX_EDGES)) begin
                    flag_ovf_reg <= 1'b1;
                end else begin
                    loaded_reg <= loaded_reg + 1'b1;
                end
            end
            if (cmd.root_init) begin
                root_reg <= '0;
            end else if (cmd.root_next) begin
                root_reg <= root_reg + 1'b1;
            end
            if (cmd.root_start) begin
                sp_reg <= (VW+1)'(1);
            end else if (cmd.push) begin
                sp_reg <= sp_reg + 1'b1;
            end else if (cmd.pop_load) begin
                sp_reg <= sp_m1;
            end
            if (cmd.clr_step) begin
                clr_reg <= stat.clr_last ? '0 : clr_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg    <= 1'b1;
                loaded_reg     <= '0;
                flag_range_reg <= 1'b0;
                flag_ovf_reg   <= 1'b0;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.cycle_found <= cmd.out_cycle;
            m_data_reg.status      <= flag_ovf_reg   ? STATUS_OVERFLOW :
                                      flag_range_reg ? STATUS_RANGE : STATUS_OK;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- src/ucd_ctrl.sv -----
// Controller state machine for loading, search, result and mark clearing.
module ucd_ctrl import ucd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      in_last,
    output logic      in_ready,
    input  ucd_stat_t stat,
    output ucd_cmd_t  cmd
);
    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_ROOT     = 4'd2;
    localparam logic [3:0] ST_ROOT_CHK = 4'd3;
    localparam logic [3:0] ST_SCAN     = 4'd4;
    localparam logic [3:0] ST_EDGE     = 4'd5;
    localparam logic [3:0] ST_VIS      = 4'd6;
    localparam logic [3:0] ST_POP      = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       found_reg;
    logic       found_next;

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        found_next    = found_reg;
        cmd           = '0;
        cmd.out_cycle = found_reg;
        in_ready      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_edge = 1'b1;
                    if (in_last) begin
                        cmd.root_init = 1'b1;
                        state_next    = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                if (stat.root_done) begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    cmd.root_rd = 1'b1;
                    state_next  = ST_ROOT_CHK;
                end
            end
            ST_ROOT_CHK: begin
                if (stat.root_visited) begin
                    cmd.root_next = 1'b1;
                    state_next    = ST_ROOT;
                end else begin
                    cmd.root_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!stat.scan_end) begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_EDGE;
                end else if (stat.sp_one) begin
                    cmd.root_next = 1'b1;
                    state_next    = ST_ROOT;
                end else begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_EDGE: begin
                if (stat.edge_match) begin
                    cmd.edge_hit = 1'b1;
                    state_next   = ST_VIS;
                end else begin
                    cmd.edge_skip = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_VIS: begin
                if (stat.other_visited) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.push   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_POP: begin
                cmd.pop_load = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

endmodule

// ----- src/undirected_cycle_detect.sv -----
// Top level of the undirected cycle detector.
//
//  channel  ports                          direction  word
//  s_       s_valid s_ready s_data         in         edge_word_t
//  m_       m_valid m_ready m_data         out        result_word_t
//  cfg_     cfg_valid cfg_ready cfg_data   in         vertex count, 9 bits
//
// Edges load at one word per cycle. The last word starts a depth-first search in
// which each edge examined takes an edge store read (ST_SCAN), then a test
// (ST_EDGE); pushes, pops and roots pass through ST_VIS, ST_POP and ST_ROOT.
// After each result and after reset all visited marks are cleared; no input
// word is taken during search or clearing.
// A waiting result stalls only the next result, not edge loading.
module undirected_cycle_detect import ucd_pkg::*; #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  edge_word_t   s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output result_word_t m_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [8:0]   cfg_data
);
    ucd_cmd_t  cmd;
    ucd_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer.
    ucd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_last  (s_data.last_edge),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    ucd_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_word  (s_data),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
